// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PGA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define PGA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/pga_pkg.sv =====
package pga_pkg;

    localparam logic [31:0] G_RESET   = 32'd662337938;
    localparam logic [30:0] SAT_MAG   = 31'h7FFF_FFFF;
    localparam int unsigned LANES     = 3;
    localparam int unsigned ROOT_BITS = 32;
    localparam int unsigned ZQ_BITS   = 31;
    localparam int unsigned XQ_BITS   = 33;
    localparam int unsigned E_OFFSET  = 37;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic signed [31:0] source_z;
        logic        [31:0] source_mass;
    } pga_in_t;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic               coincident;
        logic               clipped;
    } pga_out_t;

    // Per-word control that rides along the whole pipeline.
    typedef struct packed {
        logic [LANES-1:0] pos;     // component difference strictly positive
        logic             coinc;   // zero distance
        logic             pzero;   // G * m is zero
        logic signed [7:0] e;      // final binary exponent of the magnitude
    } pga_side_t;

    // Leading zeros of one byte, 0..8.
    function automatic logic [3:0] lzc8(input logic [7:0] b);
        logic [3:0] n;
        logic       hit;
        n   = 4'd0;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!hit) begin
                if (b[i]) begin
                    hit = 1'b1;
                end else begin
                    n = n + 4'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

// ===== hdl/pga_front.sv =====
module pga_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  pga_pkg::pga_in_t                       in_data,
    input  logic [31:0]                            grav,
    output logic                                   out_valid,
    output logic [pga_pkg::LANES-1:0][30:0]        out_v,
    output logic [63:0]                            out_s,
    output logic [62:0]                            out_pn,
    output pga_pkg::pga_side_t                     out_side
);
    import pga_pkg::*;

    logic [LANES-1:0][31:0] tgt, src;

    assign tgt[0] = in_data.target_x;
    assign tgt[1] = in_data.target_y;
    assign tgt[2] = in_data.target_z;
    assign src[0] = in_data.source_x;
    assign src[1] = in_data.source_y;
    assign src[2] = in_data.source_z;

    // Stage 1: differences and G * m
    logic                   v1_reg;
    logic [LANES-1:0][32:0] u1_reg, u1_next;
    logic [63:0]            p1_reg, p1_next;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            u1_next[i] = {tgt[i][31], tgt[i]} - {src[i][31], src[i]};
        end
        p1_next = 64'(grav) * 64'(in_data.source_mass);
    end

    // Stage 2: magnitudes, largest magnitude, special cases
    logic                   v2_reg;
    logic [LANES-1:0][31:0] mag2_reg, mag2_next;
    logic [31:0]            mx2_reg, mx2_next;
    logic [63:0]            p2_reg;
    logic [LANES-1:0]       pos2_reg, pos2_next;
    logic                   coinc2_reg, pz2_reg;

    always_comb begin
        logic [32:0] neg;
        mx2_next = 32'd0;
        for (int i = 0; i < LANES; i++) begin
            neg          = 33'd0 - u1_reg[i];
            mag2_next[i] = u1_reg[i][32] ? neg[31:0] : u1_reg[i][31:0];
            pos2_next[i] = !u1_reg[i][32] && (u1_reg[i] != 33'd0);
            if (mag2_next[i] > mx2_next) begin
                mx2_next = mag2_next[i];
            end
        end
    end

    // Stage 3: byte-wise leading zero counts
    logic                   v3_reg;
    logic [3:0][3:0]        mxc3_reg, mxc3_next;
    logic [7:0][3:0]        pc3_reg, pc3_next;
    logic [LANES-1:0][31:0] mag3_reg;
    logic [63:0]            p3_reg;
    logic [LANES-1:0]       pos3_reg;
    logic                   coinc3_reg, pz3_reg;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            mxc3_next[c] = lzc8(mx2_reg[8*c +: 8]);
        end
        for (int c = 0; c < 8; c++) begin
            pc3_next[c] = lzc8(p2_reg[8*c +: 8]);
        end
    end

    // Stage 4: merge counts, form the exponent
    logic                   v4_reg;
    logic [5:0]             lzm4_reg, lzm4_next;
    logic [6:0]             lzp4_reg, lzp4_next;
    logic [LANES-1:0][31:0] mag4_reg;
    logic [63:0]            p4_reg;
    pga_side_t              side4_reg, side4_next;

    always_comb begin
        logic       hit;
        logic [8:0] ex;
        lzm4_next = 6'd0;
        hit       = 1'b0;
        for (int c = 3; c >= 0; c--) begin
            if (!hit) begin
                lzm4_next = lzm4_next + 6'(mxc3_reg[c]);
                if (mxc3_reg[c] != 4'd8) begin
                    hit = 1'b1;
                end
            end
        end
        lzp4_next = 7'd0;
        hit       = 1'b0;
        for (int c = 7; c >= 0; c--) begin
            if (!hit) begin
                lzp4_next = lzp4_next + 7'(pc3_reg[c]);
                if (pc3_reg[c] != 4'd8) begin
                    hit = 1'b1;
                end
            end
        end
        // e = 2*lz(max) - lz(G*m) - offset
        ex               = {2'b00, lzm4_next, 1'b0} - {2'b00, lzp4_next} - 9'(E_OFFSET);
        side4_next.pos   = pos3_reg;
        side4_next.coinc = coinc3_reg;
        side4_next.pzero = pz3_reg;
        side4_next.e     = ex[7:0];
    end

    // Stage 5: normalize vector and product
    logic                   v5_reg;
    logic [LANES-1:0][30:0] vec5_reg, vec5_next;
    logic [62:0]            pn5_reg, pn5_next;
    pga_side_t              side5_reg;

    always_comb begin
        logic [31:0] sh;
        logic [63:0] psh;
        for (int i = 0; i < LANES; i++) begin
            sh           = mag4_reg[i] << lzm4_reg;
            vec5_next[i] = sh[31:1];
        end
        psh      = p4_reg << lzp4_reg;
        pn5_next = psh[63:1];
    end

    // Stage 6: squares
    logic                   v6_reg;
    logic [LANES-1:0][61:0] sq6_reg, sq6_next;
    logic [LANES-1:0][30:0] vec6_reg;
    logic [62:0]            pn6_reg;
    pga_side_t              side6_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sq6_next[i] = 62'(vec5_reg[i]) * 62'(vec5_reg[i]);
        end
    end

    // Stage 7: sum of squares
    logic                   v7_reg;
    logic [63:0]            s7_reg, s7_next;
    logic [LANES-1:0][30:0] vec7_reg;
    logic [62:0]            pn7_reg;
    pga_side_t              side7_reg;

    assign s7_next = 64'(sq6_reg[0]) + 64'(sq6_reg[1]) + 64'(sq6_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u1_reg     <= u1_next;
            p1_reg     <= p1_next;
            mag2_reg   <= mag2_next;
            mx2_reg    <= mx2_next;
            p2_reg     <= p1_reg;
            pos2_reg   <= pos2_next;
            coinc2_reg <= (mx2_next == 32'd0);
            pz2_reg    <= (p1_reg == 64'd0);
            mxc3_reg   <= mxc3_next;
            pc3_reg    <= pc3_next;
            mag3_reg   <= mag2_reg;
            p3_reg     <= p2_reg;
            pos3_reg   <= pos2_reg;
            coinc3_reg <= coinc2_reg;
            pz3_reg    <= pz2_reg;
            lzm4_reg   <= lzm4_next;
            lzp4_reg   <= lzp4_next;
            mag4_reg   <= mag3_reg;
            p4_reg     <= p3_reg;
            side4_reg  <= side4_next;
            vec5_reg   <= vec5_next;
            pn5_reg    <= pn5_next;
            side5_reg  <= side4_reg;
            sq6_reg    <= sq6_next;
            vec6_reg   <= vec5_reg;
            pn6_reg    <= pn5_reg;
            side6_reg  <= side5_reg;
            s7_reg     <= s7_next;
            vec7_reg   <= vec6_reg;
            pn7_reg    <= pn6_reg;
            side7_reg  <= side6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign out_v     = vec7_reg;
    assign out_s     = s7_reg;
    assign out_pn    = pn7_reg;
    assign out_side  = side7_reg;

endmodule

// ===== hdl/pga_root.sv =====
module pga_root (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [63:0]                            in_s,
    input  logic [pga_pkg::LANES-1:0][30:0]        in_v,
    input  logic [62:0]                            in_pn,
    input  pga_pkg::pga_side_t                     in_side,
    output logic                                   out_valid,
    output logic [31:0]                            out_q,
    output logic [30:0]                            out_z,
    output logic [pga_pkg::LANES-1:0][30:0]        out_v,
    output pga_pkg::pga_side_t                     out_side
);
    import pga_pkg::*;

    // One root bit per stage; a G*m / h quotient bit in all but the last.
    logic [ROOT_BITS-1:0]   vld_reg;
    logic [35:0]            rem_reg   [ROOT_BITS];
    logic [31:0]            root_reg  [ROOT_BITS];
    logic [63:0]            srest_reg [ROOT_BITS];
    logic [35:0]            h_reg     [ROOT_BITS];
    logic [35:0]            zr_reg    [ROOT_BITS];
    logic [30:0]            zq_reg    [ROOT_BITS];
    logic [30:0]            pnl_reg   [ROOT_BITS];
    logic [LANES-1:0][30:0] vec_reg   [ROOT_BITS];
    pga_side_t              side_reg  [ROOT_BITS];

    for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
        logic                   vld_prev;
        logic [35:0]            rem_prev, rem_ext, trial, rem_next;
        logic [31:0]            root_prev, root_next;
        logic [63:0]            srest_prev;
        logic [35:0]            h_prev, zr_prev, zr_next;
        logic [30:0]            zq_prev, zq_next, pnl_prev, pnl_next;
        logic [LANES-1:0][30:0] vec_prev;
        pga_side_t              side_prev;
        logic                   ge;

        if (j == 0) begin : g_head
            assign vld_prev   = in_valid;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign srest_prev = in_s;
            assign h_prev     = in_s[63:28];
            assign zr_prev    = {4'd0, in_pn[62:31]};
            assign zq_prev    = '0;
            assign pnl_prev   = in_pn[30:0];
            assign vec_prev   = in_v;
            assign side_prev  = in_side;
        end else begin : g_link
            assign vld_prev   = vld_reg[j-1];
            assign rem_prev   = rem_reg[j-1];
            assign root_prev  = root_reg[j-1];
            assign srest_prev = srest_reg[j-1];
            assign h_prev     = h_reg[j-1];
            assign zr_prev    = zr_reg[j-1];
            assign zq_prev    = zq_reg[j-1];
            assign pnl_prev   = pnl_reg[j-1];
            assign vec_prev   = vec_reg[j-1];
            assign side_prev  = side_reg[j-1];
        end

        // Remainder stays below 2^34, so its top two bits drop safely.
        always_comb begin
            rem_ext   = {rem_prev[33:0], srest_prev[63:62]};
            trial     = {2'b00, root_prev, 2'b01};
            ge        = (rem_ext >= trial);
            rem_next  = ge ? (rem_ext - trial) : rem_ext;
            root_next = {root_prev[30:0], ge};
        end

        if (j < ZQ_BITS) begin : g_zdiv
            logic [36:0] zr_ext, zr_diff;
            logic        zge;
            always_comb begin
                zr_ext   = {zr_prev, pnl_prev[30]};
                zr_diff  = zr_ext - {1'b0, h_prev};
                zge      = (zr_ext >= {1'b0, h_prev});
                zr_next  = zge ? zr_diff[35:0] : zr_ext[35:0];
                zq_next  = {zq_prev[29:0], zge};
                pnl_next = {pnl_prev[29:0], 1'b0};
            end
        end else begin : g_zhold
            assign zr_next  = zr_prev;
            assign zq_next  = zq_prev;
            assign pnl_next = pnl_prev;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]   <= rem_next;
                root_reg[j]  <= root_next;
                srest_reg[j] <= {srest_prev[61:0], 2'b00};
                h_reg[j]     <= h_prev;
                zr_reg[j]    <= zr_next;
                zq_reg[j]    <= zq_next;
                pnl_reg[j]   <= pnl_next;
                vec_reg[j]   <= vec_prev;
                side_reg[j]  <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_BITS-1];
    assign out_q     = root_reg[ROOT_BITS-1];
    assign out_z     = zq_reg[ROOT_BITS-1];
    assign out_v     = vec_reg[ROOT_BITS-1];
    assign out_side  = side_reg[ROOT_BITS-1];

endmodule

// ===== hdl/pga_div.sv =====
module pga_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [31:0]                            in_q,
    input  logic [30:0]                            in_z,
    input  logic [pga_pkg::LANES-1:0][30:0]        in_v,
    input  pga_pkg::pga_side_t                     in_side,
    output logic                                   out_valid,
    output logic [30:0]                            out_z,
    output logic [pga_pkg::LANES-1:0][32:0]        out_x,
    output pga_pkg::pga_side_t                     out_side
);
    import pga_pkg::*;

    // x = v * 2^32 / q, restoring, one quotient bit per stage in each lane.
    logic [XQ_BITS-1:0]     vld_reg;
    logic [LANES-1:0][31:0] r_reg    [XQ_BITS];
    logic [LANES-1:0][32:0] x_reg    [XQ_BITS];
    logic [31:0]            q_reg    [XQ_BITS];
    logic [30:0]            z_reg    [XQ_BITS];
    pga_side_t              side_reg [XQ_BITS];

    for (genvar j = 0; j < XQ_BITS; j++) begin : g_stage
        logic                   vld_prev;
        logic [LANES-1:0][31:0] r_prev, r_next;
        logic [LANES-1:0][32:0] x_prev, x_next, r_ext;
        logic [31:0]            q_prev;
        logic [30:0]            z_prev;
        pga_side_t              side_prev;

        if (j == 0) begin : g_head
            assign vld_prev  = in_valid;
            assign q_prev    = in_q;
            assign z_prev    = in_z;
            assign side_prev = in_side;
            assign x_prev    = '0;
            for (genvar i = 0; i < LANES; i++) begin : g_lane
                assign r_prev[i] = {1'b0, in_v[i]};
                assign r_ext[i]  = {1'b0, r_prev[i]};
            end
        end else begin : g_link
            assign vld_prev  = vld_reg[j-1];
            assign q_prev    = q_reg[j-1];
            assign z_prev    = z_reg[j-1];
            assign side_prev = side_reg[j-1];
            assign x_prev    = x_reg[j-1];
            assign r_prev    = r_reg[j-1];
            for (genvar i = 0; i < LANES; i++) begin : g_lane
                assign r_ext[i] = {r_prev[i], 1'b0};
            end
        end

        always_comb begin
            logic [32:0] diff;
            logic        ge;
            for (int i = 0; i < LANES; i++) begin
                diff      = r_ext[i] - {1'b0, q_prev};
                ge        = (r_ext[i] >= {1'b0, q_prev});
                r_next[i] = ge ? diff[31:0] : r_ext[i][31:0];
                x_next[i] = {x_prev[i][31:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j]    <= r_next;
                x_reg[j]    <= x_next;
                q_reg[j]    <= q_prev;
                z_reg[j]    <= z_prev;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[XQ_BITS-1];
    assign out_z     = z_reg[XQ_BITS-1];
    assign out_x     = x_reg[XQ_BITS-1];
    assign out_side  = side_reg[XQ_BITS-1];

endmodule

// ===== hdl/pga_back.sv =====
module pga_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [30:0]                            in_z,
    input  logic [pga_pkg::LANES-1:0][32:0]        in_x,
    input  pga_pkg::pga_side_t                     in_side,
    output logic                                   out_valid,
    output pga_pkg::pga_out_t                      out_data
);
    import pga_pkg::*;

    // Stage 1: z * x per lane
    logic                   v1_reg;
    logic [LANES-1:0][63:0] m1_reg, m1_next;
    pga_side_t              side1_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            m1_next[i] = 64'(in_z) * 64'(in_x[i]);
        end
    end

    // Stage 2: scale by 2^e, detect overflow
    logic                   v2_reg;
    logic [LANES-1:0][30:0] a2_reg, a2_next;
    logic [LANES-1:0]       ovf2_reg, ovf2_next;
    pga_side_t              side2_reg;

    always_comb begin
        logic [63:0] sh;
        logic [7:0]  ne;
        ne = 8'd0 - side1_reg.e;
        for (int i = 0; i < LANES; i++) begin
            if (!side1_reg.e[7]) begin
                sh           = m1_reg[i] << side1_reg.e[6:0];
                ovf2_next[i] = m1_reg[i] > (64'(SAT_MAG) >> side1_reg.e[6:0]);
            end else begin
                sh           = m1_reg[i] >> ne;
                ovf2_next[i] = sh > 64'(SAT_MAG);
            end
            a2_next[i] = sh[30:0];
        end
    end

    // Stage 3: saturate, apply sign, force special cases
    logic                   v3_reg;
    pga_out_t               out3_reg, out3_next;

    always_comb begin
        logic [LANES-1:0][31:0] acc;
        logic [30:0]            mag;
        for (int i = 0; i < LANES; i++) begin
            mag    = ovf2_reg[i] ? SAT_MAG : a2_reg[i];
            acc[i] = side2_reg.pos[i] ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
        end
        out3_next.accel_x    = acc[0];
        out3_next.accel_y    = acc[1];
        out3_next.accel_z    = acc[2];
        out3_next.coincident = side2_reg.coinc;
        out3_next.clipped    = |ovf2_reg;
        if (side2_reg.coinc || side2_reg.pzero) begin
            out3_next.accel_x = '0;
            out3_next.accel_y = '0;
            out3_next.accel_z = '0;
            out3_next.clipped = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg    <= m1_next;
            side1_reg <= in_side;
            a2_reg    <= a2_next;
            ovf2_reg  <= ovf2_next;
            side2_reg <= side1_reg;
            out3_reg  <= out3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out3_reg;

endmodule

// ===== hdl/pairwise_gravity_acceleration_top.sv =====
// Pairwise gravitational acceleration, Q8.24 fixed point.
// Input channel (s_valid/s_ready/s_data): one word per body pair, target and
// source positions plus source mass. Result channel (m_valid/m_ready/m_data):
// one word per input word, in order: acceleration -G*m*u/|u|^3 with per-lane
// saturation, a coincident flag for zero distance and a clipped flag.
// Configuration (cfg_valid/cfg_ready/cfg_data): writes G; cfg_ready is always
// high. Write it only while no pair is in flight.
// Throughput: one word per cycle while m_ready stays high. The path from input
// acceptance to m_valid runs through the 7 front stages, the 32-stage square
// root (one root bit per stage), the 33-stage restoring divider for the unit
// vector, the 3 back stages and the output register.
// Stall: when m_ready drops, the next result parks in a skid register and
// the whole pipeline holds together with s_ready low; nothing is dropped or
// repeated. s_ready does not depend on m_ready combinationally.
// Reset (aresetn low, synchronous): all valid bits clear, G returns to
// 4*pi^2 in AU, years and solar masses.
module pairwise_gravity_acceleration_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pga_pkg::pga_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pga_pkg::pga_out_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import pga_pkg::*;

    logic [31:0] g_reg;

    // Pipeline advances as long as the skid slot is free.
    logic en;

    logic                   f_valid;
    logic [LANES-1:0][30:0] f_v;
    logic [63:0]            f_s;
    logic [62:0]            f_pn;
    pga_side_t              f_side;

    logic                   r_valid;
    logic [31:0]            r_q;
    logic [30:0]            r_z;
    logic [LANES-1:0][30:0] r_v;
    pga_side_t              r_side;

    logic                   d_valid;
    logic [30:0]            d_z;
    logic [LANES-1:0][32:0] d_x;
    pga_side_t              d_side;

    logic                   p_valid;
    pga_out_t               p_data;

    logic                   out_vld_reg, skid_vld_reg;
    pga_out_t               out_data_reg, skid_data_reg;

    assign cfg_ready = 1'b1;
    assign en        = !skid_vld_reg;
    assign s_ready   = en;

    // Hold G; update only on a completed write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg <= G_RESET;
        end else if (cfg_valid && cfg_ready) begin
            g_reg <= cfg_data;
        end
    end

    pga_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .grav      (g_reg),
        .out_valid (f_valid),
        .out_v     (f_v),
        .out_s     (f_s),
        .out_pn    (f_pn),
        .out_side  (f_side)
    );

    pga_root u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_s      (f_s),
        .in_v      (f_v),
        .in_pn     (f_pn),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_q     (r_q),
        .out_z     (r_z),
        .out_v     (r_v),
        .out_side  (r_side)
    );

    pga_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_q      (r_q),
        .in_z      (r_z),
        .in_v      (r_v),
        .in_side   (r_side),
        .out_valid (d_valid),
        .out_z     (d_z),
        .out_x     (d_x),
        .out_side  (d_side)
    );

    pga_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_z      (d_z),
        .in_x      (d_x),
        .in_side   (d_side),
        .out_valid (p_valid),
        .out_data  (p_data)
    );

    // Output register plus skid slot. While the pipeline advances, the word
    // leaving the last stage goes to the output register if that is free or
    // being taken, else into the skid slot. With the skid slot full, drain it
    // into the output register on the next accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (en) begin
            if (!out_vld_reg || m_ready) begin
                out_vld_reg <= p_valid;
            end else if (p_valid) begin
                skid_vld_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!out_vld_reg || m_ready) begin
                out_data_reg <= p_data;
            end else begin
                skid_data_reg <= p_data;
            end
        end else if (m_ready) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== hdl/pga_checker.sv =====
`include "assert_macros.svh"

module pga_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input pga_pkg::pga_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input pga_pkg::pga_out_t m_data
);

    logic [31:0] sat_pos, sat_neg;
    logic        acc_zero, sat_any;

    assign sat_pos  = {1'b0, pga_pkg::SAT_MAG};
    assign sat_neg  = 32'd0 - {1'b0, pga_pkg::SAT_MAG};
    assign acc_zero = (m_data.accel_x == 32'd0) && (m_data.accel_y == 32'd0) &&
                      (m_data.accel_z == 32'd0);
    assign sat_any  = (m_data.accel_x == sat_pos) || (m_data.accel_x == sat_neg) ||
                      (m_data.accel_y == sat_pos) || (m_data.accel_y == sat_neg) ||
                      (m_data.accel_z == sat_pos) || (m_data.accel_z == sat_neg);

    `PGA_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid right after reset")

    `PGA_ASSERT(a_hold_stalled, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result word changed")

    `PGA_ASSERT(a_in_hold, s_valid && !s_ready |=> s_valid && $stable(s_data), "stalled input word changed")

    `PGA_ASSERT(a_coinc_zero, m_valid && m_data.coincident |-> acc_zero && !m_data.clipped, "coincident word not zero")

    `PGA_ASSERT(a_clip_sat, m_valid && m_data.clipped |-> sat_any, "clipped word has no saturated lane")

endmodule

bind pairwise_gravity_acceleration_top pga_checker u_pga_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
